[hw/rtl/iih_pkg.sv]
package iih_pkg;

  localparam int unsigned IIH_MAX_INTERVAL = 32768;

  localparam int unsigned IIH_CFG_IDX_W = 1;
  localparam int unsigned IIH_CFG_DATA_W = 16;

  localparam logic [IIH_CFG_IDX_W-1:0] REG_STEPS_PER_BIN = 1'd0;
  localparam logic [IIH_CFG_IDX_W-1:0] REG_BIN_LIMIT     = 1'd1;

  localparam logic [15:0] STEPS_PER_BIN_RESET = 16'd30;
  localparam logic [15:0] BIN_LIMIT_RESET     = 16'd1000;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_REPORT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [14:0] LONGEST_MAX = 15'h7fff;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        spike;
    logic [31:0] stamp;
    logic [14:0] bin_index;
  } iih_in_t;

  typedef struct packed {
    logic [31:0] bin_total;
    logic [31:0] interval_total;
    logic [14:0] largest_interval;
    logic [47:0] interval_sum;
    logic [63:0] interval_square_sum;
  } iih_out_t;

  typedef struct packed {
    logic        clear;
    logic        load_stamp;
    logic [31:0] stamp;
    logic        record;
    logic [31:0] intv;
    logic [63:0] square;
  } iih_upd_t;

  typedef struct packed {
    logic [31:0] last_stamp;
    logic [31:0] total;
    logic [14:0] longest;
    logic [47:0] sum;
    logic [63:0] square_sum;
  } iih_stats_t;

endpackage

[hw/rtl/iih_ram.sv]
module iih_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/iih_stats.sv]
module iih_stats
  import iih_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  iih_upd_t   upd_i,
  output iih_stats_t stats_o
);

  iih_stats_t stats_q, stats_d;
  logic [32:0] total_inc;
  logic [48:0] sum_add;
  logic [64:0] sq_add;

  always_comb begin
    stats_d   = stats_q;
    total_inc = {1'b0, stats_q.total} + 33'd1;
    sum_add   = {1'b0, stats_q.sum} + 49'(upd_i.intv);
    sq_add    = {1'b0, stats_q.square_sum} + {1'b0, upd_i.square};
    if (upd_i.clear) begin
      stats_d = '0;
    end else begin
      if (upd_i.load_stamp) begin
        stats_d.last_stamp = upd_i.stamp;
      end
      if (upd_i.record) begin
        stats_d.total = total_inc[32] ? '1 : total_inc[31:0];
        if (upd_i.intv > {17'd0, stats_q.longest}) begin
          stats_d.longest = (upd_i.intv > {17'd0, LONGEST_MAX}) ? LONGEST_MAX
                                                                : upd_i.intv[14:0];
        end
        stats_d.sum        = sum_add[48] ? '1 : sum_add[47:0];
        stats_d.square_sum = sq_add[64] ? '1 : sq_add[63:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stats_q <= '0;
    end else begin
      stats_q <= stats_d;
    end
  end

  assign stats_o = stats_q;

endmodule

[hw/rtl/interspike_interval_histogram_top.sv]
// Sample beat: when an interval is recorded, it passes through read, square and write-back steps.
// Report beat: the bin bounds are computed first; then one count entry is read from the memory port
// per cycle, and the result then waits in the output register until it is taken.
// Clear beat and reset: a sweep writes zero to every count entry,
// during which no beat is accepted. Configuration writes are taken at any time.
module interspike_interval_histogram_top
  import iih_pkg::*;
#(
  parameter int unsigned MAX_INTERVAL = IIH_MAX_INTERVAL
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  iih_in_t                   in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output iih_out_t                  out_data_o,
  input  logic                      cfg_we_i,
  input  logic [IIH_CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [IIH_CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_INTERVAL);
  localparam int unsigned PW = $clog2(MAX_INTERVAL + 1);
  localparam logic [31:0] MAX32 = 32'(MAX_INTERVAL);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SQ    = 3'd2;
  localparam logic [2:0] ST_SWR   = 3'd3;
  localparam logic [2:0] ST_RMUL  = 3'd4;
  localparam logic [2:0] ST_RBND  = 3'd5;
  localparam logic [2:0] ST_RRUN  = 3'd6;
  localparam logic [2:0] ST_RDONE = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [PW-1:0]   ptr_q, ptr_d;
  logic [PW-1:0]   stop_q, stop_d;
  logic [AW-1:0]   d_q, d_d;
  logic [2*AW-1:0] sq_q, sq_d;
  logic [31:0]     cnt_q, cnt_d;
  logic [30:0]     prod_q, prod_d;
  logic            inrng_q, inrng_d;
  logic [14:0]     idx_q, idx_d;
  logic [31:0]     acc_q, acc_d;
  logic            rvld_q, rvld_d;
  logic            out_valid_q, out_valid_d;
  iih_out_t        out_data_q, out_data_d;
  logic [15:0]     steps_q, limit_q;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]     ram_wdata, ram_rdata;

  iih_upd_t        upd;
  iih_stats_t      stats;

  logic [31:0]     add_a, add_b, add_sum;
  logic [32:0]     add_full;
  logic [31:0]     diff;
  logic            hit;
  logic            in_acc;
  logic            out_free;
  logic [31:0]     bnd_sum;
  logic [PW-1:0]   start_c, stop_c;

  iih_ram #(
    .WIDTH(32),
    .DEPTH(MAX_INTERVAL)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  iih_stats u_stats (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .stats_o(stats)
  );

  // Shared saturating adder: count increment and bin accumulation.
  assign add_full = {1'b0, add_a} + {1'b0, add_b};
  assign add_sum  = add_full[32] ? '1 : add_full[31:0];

  assign diff     = in_data_i.stamp - stats.last_stamp;
  assign hit      = (stats.last_stamp != 32'd0) && (diff != 32'd0) && (diff < MAX32);
  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign bnd_sum  = {1'b0, prod_q} + 32'(steps_q);
  assign start_c  = ({1'b0, prod_q} >= MAX32) ? PW'(MAX_INTERVAL) : PW'(prod_q);
  assign stop_c   = !inrng_q ? start_c
                  : (bnd_sum >= MAX32) ? PW'(MAX_INTERVAL) : PW'(bnd_sum);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    stop_d      = stop_q;
    d_d         = d_q;
    sq_d        = sq_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    inrng_d     = inrng_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    rvld_d      = 1'b0;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = d_q;
    ram_wdata   = cnt_q;
    ram_raddr   = diff[AW-1:0];
    upd         = '0;
    add_a       = acc_q;
    add_b       = ram_rdata;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q[AW-1:0];
        ram_wdata = '0;
        ptr_d     = ptr_q + PW'(1);
        if (ptr_q == PW'(MAX_INTERVAL - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.cmd)
            CMD_SAMPLE: begin
              if (in_data_i.spike) begin
                upd.load_stamp = 1'b1;
                upd.stamp      = in_data_i.stamp;
                if (hit) begin
                  d_d     = diff[AW-1:0];
                  state_d = ST_SQ;
                end
              end
            end
            CMD_REPORT: begin
              idx_d   = in_data_i.bin_index;
              inrng_d = {1'b0, in_data_i.bin_index} < limit_q;
              state_d = ST_RMUL;
            end
            CMD_CLEAR: begin
              upd.clear = 1'b1;
              ptr_d     = '0;
              state_d   = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SQ: begin
        sq_d    = (2*AW)'(d_q) * (2*AW)'(d_q);
        add_a   = ram_rdata;
        add_b   = 32'd1;
        cnt_d   = add_sum;
        state_d = ST_SWR;
      end
      ST_SWR: begin
        ram_we     = 1'b1;
        upd.record = 1'b1;
        upd.intv   = 32'(d_q);
        upd.square = 64'(sq_q);
        state_d    = ST_IDLE;
      end
      ST_RMUL: begin
        prod_d  = 31'(idx_q) * 31'(steps_q);
        state_d = ST_RBND;
      end
      ST_RBND: begin
        ptr_d   = start_c;
        stop_d  = stop_c;
        acc_d   = '0;
        state_d = ST_RRUN;
      end
      ST_RRUN: begin
        if (rvld_q) begin
          acc_d = add_sum;
        end
        if (ptr_q < stop_q) begin
          ram_raddr = ptr_q[AW-1:0];
          rvld_d    = 1'b1;
          ptr_d     = ptr_q + PW'(1);
        end else if (!rvld_q) begin
          state_d = ST_RDONE;
        end
      end
      ST_RDONE: begin
        if (out_free) begin
          out_valid_d                    = 1'b1;
          out_data_d.bin_total           = acc_q;
          out_data_d.interval_total      = stats.total;
          out_data_d.largest_interval    = stats.longest;
          out_data_d.interval_sum        = stats.sum;
          out_data_d.interval_square_sum = stats.square_sum;
          state_d                        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ptr_q       <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
      steps_q     <= STEPS_PER_BIN_RESET;
      limit_q     <= BIN_LIMIT_RESET;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      rvld_q      <= rvld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_index_i == REG_STEPS_PER_BIN)) begin
        steps_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == REG_BIN_LIMIT)) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stop_q     <= stop_d;
    d_q        <= d_d;
    sq_q       <= sq_d;
    cnt_q      <= cnt_d;
    prod_q     <= prod_d;
    inrng_q    <= inrng_d;
    idx_q      <= idx_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[hw/rtl/iih_checker.sv]
module iih_checker
  import iih_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input iih_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input iih_out_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Output beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("Output beat changed while stalled.");

  a_report_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.cmd == CMD_REPORT) |=> in_stall_o)
    else $error("Input accepted while a report was under way.");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.cmd == CMD_CLEAR) |=> in_stall_o)
    else $error("Input accepted during the clearing sweep.");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("Result appeared without a report in progress.");

endmodule

bind interspike_interval_histogram_top iih_checker u_iih_checker (.*);

[dv/tb.sv]
module tb;
  import iih_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  iih_in_t                   in_data_i;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  iih_out_t                  out_data_o;
  logic                      cfg_we_i;
  logic [IIH_CFG_IDX_W-1:0]  cfg_index_i;
  logic [IIH_CFG_DATA_W-1:0] cfg_data_i;

  interspike_interval_histogram_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  bit [31:0] hist_count [IIH_MAX_INTERVAL];
  bit [31:0] prev_stamp;
  bit [31:0] spike_total;
  bit [14:0] widest_gap;
  bit [47:0] gap_sum;
  bit [63:0] gap_square_sum;
  bit [15:0] cfg_steps;
  bit [15:0] cfg_limit;

  iih_out_t    pending_reports [$];
  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 32;
  int unsigned receiver_stall_pct = 54;
  bit [31:0]   train_stamp;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    iih_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $error("result beat arrived with no report outstanding");
        failures++;
      end else begin
        want = pending_reports.pop_front();
        check_field("bin_total", 64'(want.bin_total), 64'(out_data_o.bin_total));
        check_field("interval_total", 64'(want.interval_total),
                    64'(out_data_o.interval_total));
        check_field("largest_interval", 64'(want.largest_interval),
                    64'(out_data_o.largest_interval));
        check_field("interval_sum", 64'(want.interval_sum), 64'(out_data_o.interval_sum));
        check_field("interval_square_sum", want.interval_square_sum,
                    out_data_o.interval_square_sum);
      end
    end
  end

  task automatic clear_histogram();
    foreach (hist_count[i]) hist_count[i] = '0;
    prev_stamp     = '0;
    spike_total    = '0;
    widest_gap     = '0;
    gap_sum        = '0;
    gap_square_sum = '0;
  endtask

  function automatic bit [31:0] bin_count(bit [14:0] idx);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned acc;
    if (16'(idx) >= cfg_limit) return '0;
    lo  = 64'(idx) * 64'(cfg_steps);
    hi  = lo + 64'(cfg_steps);
    acc = 0;
    if (hi > IIH_MAX_INTERVAL) hi = IIH_MAX_INTERVAL;
    for (longint unsigned i = lo; i < hi; i++) begin
      acc += hist_count[i];
      if (acc >= 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
    end
    return acc[31:0];
  endfunction

  task automatic apply_beat(iih_in_t beat);
    bit [31:0] gap;
    bit [63:0] square;
    iih_out_t  res;
    case (beat.cmd)
      CMD_SAMPLE: begin
        if (beat.spike) begin
          gap = beat.stamp - prev_stamp;
          if (prev_stamp != 0 && gap != 0 && gap < IIH_MAX_INTERVAL) begin
            square = 64'(gap) * 64'(gap);
            if (hist_count[gap] != 32'hFFFF_FFFF) hist_count[gap]++;
            if (spike_total != 32'hFFFF_FFFF) spike_total++;
            if (gap > 32'(widest_gap)) begin
              widest_gap = (gap > 32'(LONGEST_MAX)) ? LONGEST_MAX : gap[14:0];
            end
            if (48'hFFFF_FFFF_FFFF - gap_sum < 48'(gap)) gap_sum = 48'hFFFF_FFFF_FFFF;
            else gap_sum = gap_sum + 48'(gap);
            if (64'hFFFF_FFFF_FFFF_FFFF - gap_square_sum < square) begin
              gap_square_sum = 64'hFFFF_FFFF_FFFF_FFFF;
            end else begin
              gap_square_sum = gap_square_sum + square;
            end
          end
          prev_stamp = beat.stamp;
        end
      end
      CMD_REPORT: begin
        res.bin_total           = bin_count(beat.bin_index);
        res.interval_total      = spike_total;
        res.largest_interval    = widest_gap;
        res.interval_sum        = gap_sum;
        res.interval_square_sum = gap_square_sum;
        pending_reports.push_back(res);
      end
      CMD_CLEAR: clear_histogram();
      default: ;
    endcase
  endtask

  function automatic iih_in_t make_beat(logic [1:0] cmd, logic spike, logic [31:0] stamp,
                                        logic [14:0] idx);
    iih_in_t beat;
    beat.cmd       = cmd;
    beat.spike     = spike;
    beat.stamp     = stamp;
    beat.bin_index = idx;
    return beat;
  endfunction

  task automatic send_beat(iih_in_t beat);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    apply_beat(beat);
    @(negedge clk_i);
  endtask

  task automatic send_spike(logic [31:0] stamp);
    send_beat(make_beat(CMD_SAMPLE, 1'b1, stamp, 15'($urandom)));
  endtask

  task automatic send_report(logic [14:0] idx);
    send_beat(make_beat(CMD_REPORT, 1'($urandom), 32'($urandom), idx));
  endtask

  task automatic send_clear();
    send_beat(make_beat(CMD_CLEAR, 1'($urandom), 32'($urandom), 15'($urandom)));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(logic [IIH_CFG_IDX_W-1:0] idx, logic [15:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_STEPS_PER_BIN) cfg_steps = value;
    else cfg_limit = value;
  endtask

  function automatic bit [31:0] pick_gap();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60) return 32'($urandom_range(1, 240));
    if (sel < 78) return 32'($urandom_range(1, 32767));
    if (sel < 84) return 32'd0;
    if (sel < 88) return 32'd32767;
    if (sel < 94) return 32'($urandom_range(32768, 40000));
    return 32'($urandom);
  endfunction

  task automatic test_after_reset();
    send_report(15'd0);
    send_report(15'h7fff);
  endtask

  task automatic test_interval_edges();
    send_spike(32'd0);
    send_spike(32'd5);
    send_spike(32'd5);
    send_spike(32'd6);
    send_spike(32'd6 + 32'd32767);
    send_spike(32'd6 + 32'd32767 + 32'd32768);
    send_spike(32'hFFFF_FFF0);
    send_spike(32'h0000_0010);
    send_beat(make_beat(CMD_SAMPLE, 1'b0, 32'($urandom), 15'($urandom)));
    send_beat(make_beat(CMD_UNUSED, 1'b1, 32'h0000_0020, 15'd0));
    send_report(15'd0);
    send_report(15'd1);
    send_report(15'd1092);
  endtask

  task automatic test_bin_config();
    write_register(REG_BIN_LIMIT, 16'hFFFF);
    send_report(15'd1092);
    send_report(15'h7fff);
    write_register(REG_STEPS_PER_BIN, 16'd0);
    send_report(15'd0);
    write_register(REG_STEPS_PER_BIN, 16'd1);
    send_report(15'd1);
    send_report(15'h7fff);
    write_register(REG_STEPS_PER_BIN, 16'hFFFF);
    send_report(15'd0);
    send_report(15'd1);
    write_register(REG_STEPS_PER_BIN, 16'h8000);
    send_report(15'd0);
    write_register(REG_BIN_LIMIT, 16'd0);
    send_report(15'd0);
    write_register(REG_BIN_LIMIT, 16'd1);
    write_register(REG_STEPS_PER_BIN, 16'd64);
    send_report(15'd0);
    send_report(15'd1);
    write_register(REG_STEPS_PER_BIN, STEPS_PER_BIN_RESET);
    write_register(REG_BIN_LIMIT, BIN_LIMIT_RESET);
  endtask

  task automatic test_clear();
    send_clear();
    send_report(15'd0);
    send_spike(32'd100);
    send_spike(32'd140);
    send_report(15'd1);
  endtask

  task automatic test_random_traffic(int unsigned beats, int unsigned gap_pct,
                                     int unsigned stall_pct, logic [15:0] steps,
                                     logic [15:0] limit);
    int unsigned counted;
    int unsigned clears;
    int unsigned pick;
    int unsigned useful;
    write_register(REG_STEPS_PER_BIN, steps);
    write_register(REG_BIN_LIMIT, limit);
    sender_idle_pct    = gap_pct;
    receiver_stall_pct = stall_pct;
    train_stamp = 32'($urandom);
    counted = 0;
    clears  = 0;
    while (counted < beats) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(19) == 0) train_stamp = 32'hFFFF_FFFF - 32'($urandom_range(200));
          else train_stamp += pick_gap();
          if ($urandom_range(9) == 0) begin
            send_beat(make_beat(CMD_SAMPLE, 1'b0, 32'($urandom), 15'($urandom)));
          end
          send_spike(train_stamp);
          counted++;
        end
      end else if (pick < 85) begin
        useful = (cfg_steps == 0) ? 32767 : 240 / cfg_steps + 1;
        if ($urandom_range(99) < 85) send_report(15'($urandom_range(0, useful)));
        else send_report(15'($urandom));
        counted++;
      end else if (pick < 92) begin
        send_beat(make_beat(CMD_SAMPLE, 1'b0, 32'($urandom), 15'($urandom)));
        counted++;
      end else if (pick < 96) begin
        send_beat(make_beat(CMD_UNUSED, 1'($urandom), 32'($urandom), 15'($urandom)));
      end else if (pick < 99 || clears >= 2) begin
        send_spike($urandom_range(1) ? 32'd0 : 32'($urandom));
        counted++;
      end else begin
        send_clear();
        clears++;
        counted++;
      end
    end
    send_report(15'd0);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    cfg_steps   = STEPS_PER_BIN_RESET;
    cfg_limit   = BIN_LIMIT_RESET;
    clear_histogram();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_after_reset();
    test_interval_edges();
    test_bin_config();
    test_clear();
    test_random_traffic(300, 32, 54, 16'($urandom_range(1, 8)),
                        16'($urandom_range(40, 65535)));
    test_random_traffic(300, 54, 32, 16'd1, 16'hFFFF);
    test_random_traffic(300, 0, 0, 16'($urandom_range(9, 60)),
                        16'($urandom_range(1, 12)));

    wait_idle();
    repeat (40) @(negedge clk_i);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/iih_pkg.sv
hw/rtl/iih_ram.sv
hw/rtl/iih_stats.sv
hw/rtl/interspike_interval_histogram_top.sv
hw/rtl/iih_checker.sv
dv/tb.sv
